FILE: hdl/multi_fifo_round_robin_router_macros.svh
// Assertion macros used by the router RTL.
`ifndef MULTI_FIFO_ROUND_ROBIN_ROUTER_MACROS_SVH
`define MULTI_FIFO_ROUND_ROBIN_ROUTER_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define MFRR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("router check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define MFRR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("router check failed");

`endif

FILE: hdl/mfrr_pkg.sv
`default_nettype none

package mfrr_pkg;

  localparam int QUEUE_DEPTH = 8;
  localparam int QUEUE_COUNT = 4;

  // Queue number and per-queue fill count widths.
  localparam int QW = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  // Fixed field widths of the interface.
  localparam int TAG_W    = 2;
  localparam int SRC_W    = 2;
  localparam int QFIELD_W = 2;
  localparam int STAT_W   = 2;
  localparam int OCC_W    = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 2;

  // Commands.
  localparam logic CMD_PUT    = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  // Sources.
  localparam logic [SRC_W-1:0] SRC_ZERO  = 2'd0;
  localparam logic [SRC_W-1:0] SRC_ONE   = 2'd1;
  localparam logic [SRC_W-1:0] SRC_RR    = 2'd2;
  localparam logic [SRC_W-1:0] SRC_NONE  = 2'd3;

  // Result status codes.
  localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STAT_W-1:0] ST_NOSRC = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_ROUTE_ZERO = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROUTE_ONE  = 2'd1;

  // Control into one queue.
  typedef struct packed {
    logic             push;
    logic             pop;
    logic [TAG_W-1:0] tag;
  } mfrr_qctl_t;

  // Status out of one queue.
  typedef struct packed {
    logic [CW-1:0]    count;
    logic [TAG_W-1:0] head;
  } mfrr_qstat_t;

  // Reduce a two-bit queue number modulo the queue count. The value is below
  // four, so at most one subtraction is needed.
  function automatic logic [QW-1:0] fold_queue(input logic [QFIELD_W-1:0] v);
    int unsigned x;
    x = int'(v);
    if (x >= QUEUE_COUNT) begin
      x = x - QUEUE_COUNT;
    end
    if (x >= QUEUE_COUNT) begin
      x = x - QUEUE_COUNT;
    end
    return QW'(x);
  endfunction

endpackage

`default_nettype wire

FILE: hdl/multi_fifo_round_robin_router.sv
`default_nettype none

// Round-robin multi-queue router. The block holds QUEUE_COUNT first-in
// first-out queues of two-bit tags, each QUEUE_DEPTH entries deep. A put
// item (command 0) from source 0 or 1 stores into the queue named by the
// route_source_zero or route_source_one register; source 2 stores into the
// queue under the round-robin pointer, which then moves on by one. The tag
// stored is the source number plus one, and source 3 is refused with status
// 3. A remove item (command 1) pops the oldest tag of target_queue. A put
// into a full queue or a remove from an empty one is refused with status 1
// or 2 and changes nothing. Each item gives exactly one result: the status,
// the queue addressed, the popped tag (0 unless a remove succeeded) and the
// queue's occupancy afterwards. Every item is decided in the cycle it is
// accepted and its result is registered, so the block takes one item per
// clock cycle while in_stall is low, and the result appears in the cycle
// after its item in the single output register; in_stall is raised only
// while a result is held there under out_stall. Each queue is a chain of
// cells that all shift one place towards the head on a pop. Configuration
// writes are always ready and should be made only while the block is idle.
module multi_fifo_round_robin_router (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // Item input channel.
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic                           in_command,
  input  wire logic [mfrr_pkg::SRC_W-1:0]     in_source,
  input  wire logic [mfrr_pkg::QFIELD_W-1:0]  in_target_queue,
  // Result channel.
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic      [mfrr_pkg::STAT_W-1:0]    out_status,
  output logic      [mfrr_pkg::QFIELD_W-1:0]  out_queue_used,
  output logic      [mfrr_pkg::TAG_W-1:0]     out_popped_tag,
  output logic      [mfrr_pkg::OCC_W-1:0]     out_occupancy,
  // Configuration write channel.
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [mfrr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [mfrr_pkg::CFG_DATA_W-1:0] cfg_data
);
  import mfrr_pkg::*;

  `include "multi_fifo_round_robin_router_macros.svh"

  // Configuration registers.
  logic [CFG_DATA_W-1:0] route_zero_r;
  logic [CFG_DATA_W-1:0] route_one_r;

  // Round-robin pointer.
  logic [QW-1:0] rr_ptr_r;
  logic [QW-1:0] rr_ptr_nxt;

  // Output register.
  logic                out_valid_r;
  logic [STAT_W-1:0]   status_r;
  logic [QFIELD_W-1:0] queue_used_r;
  logic [TAG_W-1:0]    popped_tag_r;
  logic [OCC_W-1:0]    occupancy_r;

  // Decision of the current item.
  logic                in_accept;
  logic [QW-1:0]       q_sel;
  logic [CW-1:0]       q_count;
  logic [STAT_W-1:0]   res_status;
  logic [QW-1:0]       res_queue;
  logic [TAG_W-1:0]    res_tag;
  logic [CW-1:0]       res_occ;
  logic                do_push;
  logic                do_pop;

  mfrr_qctl_t  q_ctl  [QUEUE_COUNT];
  mfrr_qstat_t q_stat [QUEUE_COUNT];

  // The result register empties as it is taken, so a new item may be taken
  // in the same cycle.
  assign in_stall  = out_valid_r && out_stall;
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      route_zero_r <= CFG_DATA_W'(0);
      route_one_r  <= CFG_DATA_W'(3);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ROUTE_ZERO: route_zero_r <= cfg_data;
        REG_ROUTE_ONE:  route_one_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pick the queue the item addresses.
  always_comb begin
    if (in_command == CMD_REMOVE) begin
      q_sel = fold_queue(in_target_queue);
    end else begin
      case (in_source)
        SRC_ZERO: q_sel = fold_queue(route_zero_r);
        SRC_ONE:  q_sel = fold_queue(route_one_r);
        default:  q_sel = rr_ptr_r;
      endcase
    end
  end

  assign q_count = q_stat[q_sel].count;

  always_comb begin
    res_status = ST_DONE;
    res_queue  = q_sel;
    res_tag    = '0;
    res_occ    = q_count;
    do_push    = 1'b0;
    do_pop     = 1'b0;
    if (in_command == CMD_PUT) begin
      if (in_source == SRC_NONE) begin
        res_status = ST_NOSRC;
        res_queue  = '0;
        res_occ    = '0;
      end else if (q_count >= CW'(QUEUE_DEPTH)) begin
        res_status = ST_FULL;
      end else begin
        do_push = 1'b1;
        res_occ = q_count + CW'(1);
      end
    end else begin
      if (q_count == '0) begin
        res_status = ST_EMPTY;
        res_occ    = '0;
      end else begin
        do_pop  = 1'b1;
        res_tag = q_stat[q_sel].head;
        res_occ = q_count - CW'(1);
      end
    end
  end

  // Per-queue control: only the addressed queue moves.
  for (genvar g = 0; g < QUEUE_COUNT; g++) begin : g_queue
    assign q_ctl[g].push = in_accept && do_push && (q_sel == QW'(g));
    assign q_ctl[g].pop  = in_accept && do_pop && (q_sel == QW'(g));
    assign q_ctl[g].tag  = TAG_W'(in_source + SRC_W'(1));

    mfrr_queue u_queue (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl   (q_ctl[g]),
      .stat  (q_stat[g])
    );
  end

  // The pointer moves on only after a successful round-robin put.
  always_comb begin
    rr_ptr_nxt = rr_ptr_r;
    if (in_accept && do_push && (in_source == SRC_RR)) begin
      if (q_sel == QW'(QUEUE_COUNT - 1)) begin
        rr_ptr_nxt = '0;
      end else begin
        rr_ptr_nxt = q_sel + QW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rr_ptr_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      rr_ptr_r <= rr_ptr_nxt;
      if (in_accept) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      status_r     <= res_status;
      queue_used_r <= QFIELD_W'(res_queue);
      popped_tag_r <= res_tag;
      occupancy_r  <= OCC_W'(res_occ);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = status_r;
  assign out_queue_used = queue_used_r;
  assign out_popped_tag = popped_tag_r;
  assign out_occupancy  = occupancy_r;

  // An accepted item always leaves a result in the next cycle.
  `MFRR_ASSERT_NEXT(a_result_follows, clk, rst_n, in_accept, out_valid_r)
  // A refused remove reports an empty queue and no tag.
  `MFRR_ASSERT_NOW(a_empty_result, clk, rst_n, out_valid_r && (status_r == ST_EMPTY),
    (occupancy_r == '0) && (popped_tag_r == '0))
  // The pointer moves only after an accepted round-robin put.
  `MFRR_ASSERT_NOW(a_rr_moves, clk, rst_n, rr_ptr_r != $past(rr_ptr_r),
    $past(in_accept) && ($past(in_command) == CMD_PUT) && ($past(in_source) == SRC_RR))
  // No queue ever reports more entries than it can hold.
  `MFRR_ASSERT_NOW(a_occ_bound, clk, rst_n, out_valid_r,
    occupancy_r <= OCC_W'(QUEUE_DEPTH))

endmodule

`default_nettype wire

FILE: hdl/mfrr_cell.sv
`default_nettype none

// One storage position of a queue. It takes a new tag when written, or its
// neighbour's tag when the queue pops.
module mfrr_cell (
  input  wire logic                      clk,
  input  wire logic                      load_en,
  input  wire logic                      shift_en,
  input  wire logic [mfrr_pkg::TAG_W-1:0] load_tag,
  input  wire logic [mfrr_pkg::TAG_W-1:0] next_tag,
  output logic      [mfrr_pkg::TAG_W-1:0] tag
);
  import mfrr_pkg::*;

  logic [TAG_W-1:0] tag_r;
  logic [TAG_W-1:0] tag_nxt;

  always_comb begin
    tag_nxt = tag_r;
    if (load_en) begin
      tag_nxt = load_tag;
    end else if (shift_en) begin
      tag_nxt = next_tag;
    end
  end

  always_ff @(posedge clk) begin
    tag_r <= tag_nxt;
  end

  assign tag = tag_r;

endmodule

`default_nettype wire

FILE: hdl/mfrr_queue.sv
`default_nettype none

// One queue: a chain of cells with the oldest tag in cell zero, and a count.
module mfrr_queue (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire mfrr_pkg::mfrr_qctl_t ctl,
  output mfrr_pkg::mfrr_qstat_t     stat
);
  import mfrr_pkg::*;

  logic [CW-1:0]    count_r;
  logic [CW-1:0]    count_nxt;
  logic [TAG_W-1:0] chain [QUEUE_DEPTH+1];

  assign chain[QUEUE_DEPTH] = '0;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    mfrr_cell u_cell (
      .clk      (clk),
      .load_en  (ctl.push && (count_r == CW'(i))),
      .shift_en (ctl.pop),
      .load_tag (ctl.tag),
      .next_tag (chain[i+1]),
      .tag      (chain[i])
    );
  end

  always_comb begin
    count_nxt = count_r;
    if (ctl.push) begin
      count_nxt = count_r + CW'(1);
    end else if (ctl.pop) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  assign stat.count = count_r;
  assign stat.head  = chain[0];

endmodule

`default_nettype wire

FILE: bench/testbench.sv
`default_nettype none

// Bench for the round-robin multi-queue router.
//
// An initial block builds the items to send, phase by phase, and pushes
// them onto a queue. A clocked driver takes them from that queue and
// presents them at the falling edge, in bursts of random length with random
// gaps between them. A clocked monitor watches both channels at the rising
// edge. Every item that the block accepts is run through a local model of
// the queues, and the outcome that the model predicts is queued. Every result
// that the block hands over is compared with the oldest prediction.
//
// The receiver stalls on a pattern that changes mode from time to time. A
// separate process also holds it off for long stretches, so the single
// output register fills and the block has to stall its input while the
// driver keeps offering items.
//
// The routing registers are written only when nothing is in flight: after
// reset and between phases.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import mfrr_pkg::*;

  localparam int ITEMS_PER_PHASE = 190;
  localparam int PHASES          = 8;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int REPORT_LIMIT    = 10;

  // Indexes past the end of the register list; the block must ignore them.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_TWO   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_THREE = 2'd3;

  typedef enum logic [1:0] {
    STALL_NEVER,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_ALTERNATE
  } stall_mode_t;

  typedef struct packed {
    logic                command;
    logic [SRC_W-1:0]    source;
    logic [QFIELD_W-1:0] target_queue;
  } request_t;

  typedef struct packed {
    logic [STAT_W-1:0]   status;
    logic [QFIELD_W-1:0] queue_used;
    logic [TAG_W-1:0]    popped_tag;
    logic [OCC_W-1:0]    occupancy;
  } outcome_t;

  // Every input of the block holds a known value from time zero.
  logic                  clk             = 1'b0;
  logic                  rst_n           = 1'b0;
  logic                  in_valid        = 1'b0;
  logic                  in_command      = CMD_PUT;
  logic [SRC_W-1:0]      in_source       = SRC_ZERO;
  logic [QFIELD_W-1:0]   in_target_queue = '0;
  logic                  out_stall       = 1'b0;
  logic                  cfg_valid       = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index       = REG_ROUTE_ZERO;
  logic [CFG_DATA_W-1:0] cfg_data        = '0;

  logic                  in_stall;
  logic                  out_valid;
  logic [STAT_W-1:0]     out_status;
  logic [QFIELD_W-1:0]   out_queue_used;
  logic [TAG_W-1:0]      out_popped_tag;
  logic [OCC_W-1:0]      out_occupancy;
  logic                  cfg_ready;

  multi_fifo_round_robin_router DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_command      (in_command),
    .in_source       (in_source),
    .in_target_queue (in_target_queue),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_queue_used  (out_queue_used),
    .out_popped_tag  (out_popped_tag),
    .out_occupancy   (out_occupancy),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #5ns clk = ~clk;

  // Items waiting to be sent, and outcomes waiting for their result.
  request_t requests_to_send [$];
  outcome_t outcomes_due [$];

  // Local copy of the queues, the routing registers and the spreading
  // pointer. Only the entries below a queue's count are ever read.
  logic [TAG_W-1:0]      held_tags  [QUEUE_COUNT][QUEUE_DEPTH];
  logic [CW-1:0]         held_count [QUEUE_COUNT] = '{default: '0};
  logic [QW-1:0]         spread_next = '0;
  logic [CFG_DATA_W-1:0] zero_route  = 2'd0;
  logic [CFG_DATA_W-1:0] one_route   = 2'd3;

  int          failures   = 0;
  int          cycles     = 0;
  int          burst_left = 0;
  int          gap_left   = 0;
  logic        item_taken = 1'b0;
  logic        hold_active = 1'b0;
  stall_mode_t stall_mode = STALL_NEVER;
  int          stall_left = 0;
  logic        stall_toggle = 1'b0;
  int          hold_clock = 0;
  int          hold_left  = 0;

  task automatic report_failure(input string what);
    failures++;
    if (failures <= REPORT_LIMIT) begin
      $display("%s", what);
    end
  endtask

  // Works out what the block must answer to one accepted item, and updates
  // the local queues in the same way. A queue number is reduced modulo the
  // number of queues, which matters only if the block is built with fewer
  // queues than a two-bit field can name.
  task automatic route_request(input request_t req);
    outcome_t o;
    int       q;
    o = '0;
    o.status = ST_DONE;
    if (req.command == CMD_PUT) begin
      if (req.source == SRC_NONE) begin
        // There is no fourth source: refused, and every other field is zero.
        o.status = ST_NOSRC;
      end else begin
        if (req.source == SRC_ZERO) begin
          q = int'(zero_route) % QUEUE_COUNT;
        end else if (req.source == SRC_ONE) begin
          q = int'(one_route) % QUEUE_COUNT;
        end else begin
          q = int'(spread_next) % QUEUE_COUNT;
        end
        o.queue_used = QFIELD_W'(q);
        if (held_count[q] >= QUEUE_DEPTH) begin
          // A full queue refuses the put, and the pointer stays where it is.
          o.status    = ST_FULL;
          o.occupancy = OCC_W'(held_count[q]);
        end else begin
          held_tags[q][held_count[q]] = TAG_W'(req.source + 2'd1);
          held_count[q] = held_count[q] + 1'b1;
          if (req.source == SRC_RR) begin
            spread_next = QW'((q + 1) % QUEUE_COUNT);
          end
          o.occupancy = OCC_W'(held_count[q]);
        end
      end
    end else begin
      q = int'(req.target_queue) % QUEUE_COUNT;
      o.queue_used = QFIELD_W'(q);
      if (held_count[q] == 0) begin
        o.status = ST_EMPTY;
      end else begin
        o.popped_tag = held_tags[q][0];
        for (int i = 0; i + 1 < int'(held_count[q]); i++) begin
          held_tags[q][i] = held_tags[q][i + 1];
        end
        held_count[q] = held_count[q] - 1'b1;
        o.occupancy = OCC_W'(held_count[q]);
      end
    end
    outcomes_due.push_back(o);
  endtask

  task automatic queue_request(input logic cmd, input logic [SRC_W-1:0] src,
                               input logic [QFIELD_W-1:0] tgt);
    request_t r;
    r.command      = cmd;
    r.source       = src;
    r.target_queue = tgt;
    requests_to_send.push_back(r);
  endtask

  // Polled at the rising edge, where the driver never acts, so that an item
  // being picked from the queue cannot be missed.
  task automatic wait_until_drained();
    while (requests_to_send.size() != 0 || in_valid || outcomes_due.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do begin
      @(posedge clk);
    end while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Driver. A new item may be presented once the previous one has been taken
  // or when nothing is on offer; a stalled item is held as it is. Bursts end
  // with a gap of random length, and some bursts run straight into the next.
  always @(negedge clk) begin
    request_t r;
    if (rst_n && (!in_valid || item_taken)) begin
      if (gap_left != 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (requests_to_send.size() != 0) begin
        r = requests_to_send.pop_front();
        in_command      <= r.command;
        in_source       <= r.source;
        in_target_queue <= r.target_queue;
        in_valid        <= 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stall pattern. The mode changes after a random number of
  // cycles, so quiet stretches alternate with light, heavy and regular
  // stalling. A long hold-off from the process below overrides it.
  always @(negedge clk) begin
    logic s;
    if (stall_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(3));
      stall_left = $urandom_range(20, 200);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      STALL_NEVER:     s = 1'b0;
      STALL_LIGHT:     s = ($urandom_range(3) == 0);
      STALL_HEAVY:     s = ($urandom_range(3) != 0);
      default: begin
        stall_toggle = ~stall_toggle;
        s = stall_toggle;
      end
    endcase
    out_stall <= hold_active || s;
  end

  // Long hold-offs of the receiver, counted in cycles of their own, placed
  // where the random phases are running so that the driver keeps offering
  // items and the block has to stall its input.
  always @(negedge clk) begin
    hold_clock++;
    if (hold_clock == 400 || hold_clock == 2500) begin
      hold_left = 250;
    end else if (hold_left != 0) begin
      hold_left--;
    end
    hold_active <= (hold_left != 0);
  end

  // Monitor. The result is checked before the item of the same edge is
  // modelled, so that a result can only ever meet an earlier prediction.
  always @(posedge clk) begin
    outcome_t got;
    outcome_t want;
    request_t req;
    if (!rst_n) begin
      item_taken <= 1'b0;
    end else begin
      item_taken <= in_valid && !in_stall;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ROUTE_ZERO: zero_route = cfg_data;
          REG_ROUTE_ONE:  one_route  = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        got.status     = out_status;
        got.queue_used = out_queue_used;
        got.popped_tag = out_popped_tag;
        got.occupancy  = out_occupancy;
        if (outcomes_due.size() == 0) begin
          report_failure($sformatf(
            "unexpected result: status %0d queue %0d tag %0d occupancy %0d",
            got.status, got.queue_used, got.popped_tag, got.occupancy));
        end else begin
          want = outcomes_due.pop_front();
          if (got.status !== want.status || got.queue_used !== want.queue_used ||
              got.popped_tag !== want.popped_tag || got.occupancy !== want.occupancy) begin
            report_failure($sformatf(
              "mismatch: expected status %0d queue %0d tag %0d occupancy %0d, got %0d %0d %0d %0d",
              want.status, want.queue_used, want.popped_tag, want.occupancy,
              got.status, got.queue_used, got.popped_tag, got.occupancy));
          end
        end
      end
      if (in_valid && !in_stall) begin
        req.command      = in_command;
        req.source       = in_source;
        req.target_queue = in_target_queue;
        route_request(req);
      end
    end
  end

  // Watchdog: a missing result or a block that never takes an item ends the
  // run here.
  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    request_t              r;
    int                    put_share;
    int                    roll;
    logic [CFG_DATA_W-1:0] zr;
    logic [CFG_DATA_W-1:0] or_;

    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // Directed part, with the routing registers at their reset values:
    // source 0 into queue 0, source 1 into queue 3.
    // Spread one item over every queue, leaving the pointer back at queue 0.
    for (int q = 0; q < 4; q++) begin
      queue_request(CMD_PUT, SRC_RR, QFIELD_W'(3 - q));
    end
    // Fill queue 0; the eighth of these finds it full.
    for (int i = 0; i < 8; i++) begin
      queue_request(CMD_PUT, SRC_ZERO, QFIELD_W'(i));
    end
    // A spread put meets the full queue, so the pointer must not move on:
    // after one removal the next spread put lands in queue 0 again.
    queue_request(CMD_PUT, SRC_RR, 2'd0);
    queue_request(CMD_REMOVE, SRC_NONE, 2'd0);
    queue_request(CMD_PUT, SRC_RR, 2'd3);
    queue_request(CMD_PUT, SRC_ONE, 2'd1);
    // No such source.
    queue_request(CMD_PUT, SRC_NONE, 2'd3);
    queue_request(CMD_REMOVE, SRC_ZERO, 2'd1);
    queue_request(CMD_REMOVE, SRC_ONE, 2'd1);
    queue_request(CMD_REMOVE, SRC_RR, 2'd2);
    queue_request(CMD_REMOVE, SRC_ZERO, 2'd3);
    queue_request(CMD_REMOVE, SRC_NONE, 2'd3);
    // Queue 3 is empty by now.
    queue_request(CMD_REMOVE, SRC_ONE, 2'd3);
    wait_until_drained();
    repeat (4) @(posedge clk);

    // Random phases, each under its own routing. Phases alternate between
    // mostly puts, which drive queues to full, and mostly removals, which
    // drain them to empty. The queue contents carry over between phases.
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin zr = 2'd3; or_ = 2'd0; end
        1: begin zr = 2'd1; or_ = 2'd1; end
        2: begin zr = 2'd0; or_ = 2'd3; end
        3: begin zr = 2'd2; or_ = 2'd2; end
        4: begin zr = 2'd3; or_ = 2'd3; end
        5: begin zr = 2'd0; or_ = 2'd0; end
        default: begin
          zr  = CFG_DATA_W'($urandom_range(3));
          or_ = CFG_DATA_W'($urandom_range(3));
        end
      endcase
      write_register(REG_ROUTE_ZERO, zr);
      write_register(REG_ROUTE_ONE, or_);
      if (phase == 2 || phase == 5) begin
        write_register(REG_SPARE_TWO, CFG_DATA_W'($urandom_range(3)));
        write_register(REG_SPARE_THREE, CFG_DATA_W'($urandom_range(3)));
      end
      put_share = (phase % 2 == 0) ? $urandom_range(60, 90) : $urandom_range(15, 45);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        r.command = ($urandom_range(99) < put_share) ? CMD_PUT : CMD_REMOVE;
        roll = $urandom_range(99);
        // A few puts name the missing source; the rest are well formed.
        if (roll < 4) begin
          r.source = SRC_NONE;
        end else if (roll < 36) begin
          r.source = SRC_ZERO;
        end else if (roll < 68) begin
          r.source = SRC_ONE;
        end else begin
          r.source = SRC_RR;
        end
        r.target_queue = QFIELD_W'($urandom_range(3));
        requests_to_send.push_back(r);
      end
      wait_until_drained();
      repeat (4) @(posedge clk);
    end

    wait_until_drained();
    repeat (8) @(posedge clk);
    if (outcomes_due.size() != 0) begin
      report_failure($sformatf("%0d results never arrived", outcomes_due.size()));
    end
    if (failures == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: filelist.f
+incdir+hdl
hdl/mfrr_pkg.sv
hdl/mfrr_cell.sv
hdl/mfrr_queue.sv
hdl/multi_fifo_round_robin_router.sv
bench/testbench.sv
